// File: design/lsi_pkg.sv
`timescale 1ns / 1ps

package lsi_pkg;

  // default coordinate width and fixed point fraction width
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // fixed width of each reported crossing coordinate
  localparam int CROSS_W = 64;

  // result transaction: parallel, x, y, on-segments, saturated, padded to bytes
  localparam int RES_BITS = 1 + CROSS_W + CROSS_W + 1 + 1;
  localparam int RES_TW   = ((RES_BITS + 7) / 8) * 8;

endpackage

// File: design/line_segment_intersection_core.sv
`timescale 1ns / 1ps

// Line segment intersection core. Each input transaction carries two segments
// (start and end point of segment a, then of segment b) as signed COORD_BITS-bit
// integers. For each line the core forms A = y2 - y1, B = x1 - x2 and
// C = A*x1 + B*y1, then det = A1*B2 - B1*A2. A zero det flags the pair as
// parallel (also any degenerate segment) and clears every other result field.
// Otherwise the crossing is x = (C1*B2 - B1*C2)/det, y = (A1*C2 - A2*C1)/det,
// reported in signed 64-bit fixed point with FRAC_BITS fraction bits,
// truncated toward zero and clipped to the 64-bit range (saturated flag set
// when either coordinate was clipped). on_both_segments compares the exact
// rational crossing against the closed bounding boxes of both segments, so
// truncation and clipping never affect it. All arithmetic is exact integer.
// Throughput is one transaction per clock; the pipeline is fully stalled only
// when the two-entry output buffer is full. A result passes through six
// stages of multiply and add, the divider load register, the restoring
// divider, which retires one quotient bit per pipeline stage over
// 3*COORD_BITS + 4 + FRAC_BITS stages, and the output register. No clearing
// or start-up period after reset.
module line_segment_intersection_core #(
  parameter int COORD_BITS = lsi_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lsi_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_BITS-1:0]     s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // is_parallel, cross_x, cross_y, on_both_segments, saturated, zero padding
  output logic [lsi_pkg::RES_TW-1:0]  m_axis_tdata_o
);

  localparam int N    = COORD_BITS;
  localparam int AW   = N + 1;          // A and B
  localparam int PW   = 2 * N + 1;      // A*x terms
  localparam int DPW  = 2 * N + 2;      // det terms
  localparam int CW   = 2 * N + 2;      // C
  localparam int DTW  = 2 * N + 3;      // det
  localparam int NPW  = 3 * N + 3;      // numerator terms
  localparam int MW   = 3 * N + 4;      // numerators
  localparam int BPW  = N + DTW + 1;    // bounding box products
  localparam int DW   = MW + FRAC_BITS; // dividend and quotient bits
  localparam int RW   = DTW + 1;        // trial remainder
  localparam int XW   = lsi_pkg::CROSS_W;
  localparam int QXW  = (DW > XW) ? DW : XW + 1;
  localparam int PADW = lsi_pkg::RES_TW - lsi_pkg::RES_BITS;

  localparam logic [QXW-1:0] NEG_LIM = QXW'({1'b1, {(XW-1){1'b0}}});
  localparam logic [QXW-1:0] POS_LIM = QXW'({1'b0, {(XW-1){1'b1}}});

  // whole pipeline advances while the skid entry is empty
  logic en;

  // ---------------------------------------------------------------- stage 1
  // coordinates, A and B of both lines
  logic signed [N-1:0]  pt_in [8];
  logic signed [N-1:0]  s1_pt_q [8];
  logic signed [AW-1:0] s1_a1_q, s1_b1_q, s1_a2_q, s1_b2_q;
  logic                 s1_v_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pt_in[i] = s_axis_tdata_i[i*N +: N];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // products for C and det
  logic signed [N-1:0]   s2_pt_q [8];
  logic signed [AW-1:0]  s2_a1_q, s2_b1_q, s2_a2_q, s2_b2_q;
  logic signed [PW-1:0]  s2_ax1_q, s2_by1_q, s2_ax2_q, s2_by2_q;
  logic signed [DPW-1:0] s2_d1_q, s2_d2_q;
  logic                  s2_v_q;

  // ---------------------------------------------------------------- stage 3
  // C1, C2 and det
  logic signed [N-1:0]  s3_pt_q [8];
  logic signed [AW-1:0] s3_a1_q, s3_b1_q, s3_a2_q, s3_b2_q;
  logic signed [CW-1:0] s3_c1_q, s3_c2_q;
  logic signed [DTW-1:0] s3_det_q;
  logic                  s3_v_q;

  // ---------------------------------------------------------------- stage 4
  // numerator products
  logic signed [N-1:0]   s4_pt_q [8];
  logic signed [NPW-1:0] s4_nx1_q, s4_nx2_q, s4_ny1_q, s4_ny2_q;
  logic signed [DTW-1:0] s4_det_q;
  logic                  s4_v_q;

  // ---------------------------------------------------------------- stage 5
  // numerators normalized to a positive det, box limits
  logic signed [MW-1:0] s5_nx_d, s5_ny_d, s5_nx_q, s5_ny_q;
  logic [DTW-1:0]       s5_den_d, s5_den_q;
  logic                 s5_par_q;
  logic signed [N-1:0]  s5_lo_d [4];
  logic signed [N-1:0]  s5_hi_d [4];
  logic signed [N-1:0]  s5_lo_q [4];
  logic signed [N-1:0]  s5_hi_q [4];
  logic                 s5_v_q;

  always_comb begin
    logic signed [MW-1:0] nx, ny;
    int base;
    nx = MW'(s4_nx1_q) - MW'(s4_nx2_q);
    ny = MW'(s4_ny1_q) - MW'(s4_ny2_q);
    if (s4_det_q[DTW-1]) begin
      s5_nx_d  = -nx;
      s5_ny_d  = -ny;
      s5_den_d = DTW'(~s4_det_q + 1'b1);
    end else begin
      s5_nx_d  = nx;
      s5_ny_d  = ny;
      s5_den_d = s4_det_q;
    end
    // limit pairs: a x, a y, b x, b y
    for (int j = 0; j < 4; j++) begin
      base = (j / 2) * 4 + (j % 2);
      if (s4_pt_q[base] < s4_pt_q[base+2]) begin
        s5_lo_d[j] = s4_pt_q[base];
        s5_hi_d[j] = s4_pt_q[base+2];
      end else begin
        s5_lo_d[j] = s4_pt_q[base+2];
        s5_hi_d[j] = s4_pt_q[base];
      end
    end
  end

  // ---------------------------------------------------------------- stage 6
  // box limits scaled by det, numerator magnitudes
  logic signed [MW-1:0]  s6_nx_q, s6_ny_q;
  logic [MW-1:0]         s6_magx_q, s6_magy_q;
  logic                  s6_negx_q, s6_negy_q;
  logic [DTW-1:0]        s6_den_q;
  logic                  s6_par_q;
  logic signed [BPW-1:0] s6_lop_q [4];
  logic signed [BPW-1:0] s6_hip_q [4];
  logic signed [DTW:0]   den_s;
  logic                  s6_v_q;

  assign den_s = $signed({1'b0, s5_den_q});

  // ---------------------------------------------------------------- divider
  // index 0 holds the loaded operands, index DW the finished quotients
  logic            dv_v_q    [DW+1];
  logic [DTW-1:0]  dv_den_q  [DW+1];
  logic [DTW-1:0]  dv_remx_q [DW+1];
  logic [DTW-1:0]  dv_remy_q [DW+1];
  logic [DW-1:0]   dv_wx_q   [DW+1];   // dividend bits shift out, quotient bits in
  logic [DW-1:0]   dv_wy_q   [DW+1];
  logic            dv_negx_q [DW+1];
  logic            dv_negy_q [DW+1];
  logic            dv_par_q  [DW+1];
  logic            dv_on_q   [DW+1];

  logic [DTW-1:0]  dv_remx_d [DW+1];
  logic [DTW-1:0]  dv_remy_d [DW+1];
  logic [DW-1:0]   dv_wx_d   [DW+1];
  logic [DW-1:0]   dv_wy_d   [DW+1];
  logic            on_d;

  // exact bounding box test on the rational point
  always_comb begin
    on_d = 1'b1;
    for (int j = 0; j < 4; j++) begin
      if (j % 2 == 0) begin
        if ((s6_nx_q < s6_lop_q[j]) || (s6_nx_q > s6_hip_q[j])) on_d = 1'b0;
      end else begin
        if ((s6_ny_q < s6_lop_q[j]) || (s6_ny_q > s6_hip_q[j])) on_d = 1'b0;
      end
    end
  end

  // one restoring step per stage for each coordinate
  always_comb begin
    logic [RW-1:0] tx, ty;
    logic [RW-1:0] dd;
    dv_remx_d[0] = '0;
    dv_remy_d[0] = '0;
    dv_wx_d[0]   = DW'(s6_magx_q) << FRAC_BITS;
    dv_wy_d[0]   = DW'(s6_magy_q) << FRAC_BITS;
    for (int k = 0; k < DW; k++) begin
      dd = {1'b0, dv_den_q[k]};
      tx = {dv_remx_q[k], dv_wx_q[k][DW-1]};
      ty = {dv_remy_q[k], dv_wy_q[k][DW-1]};
      if (tx >= dd) begin
        tx = tx - dd;
        dv_wx_d[k+1] = {dv_wx_q[k][DW-2:0], 1'b1};
      end else begin
        dv_wx_d[k+1] = {dv_wx_q[k][DW-2:0], 1'b0};
      end
      if (ty >= dd) begin
        ty = ty - dd;
        dv_wy_d[k+1] = {dv_wy_q[k][DW-2:0], 1'b1};
      end else begin
        dv_wy_d[k+1] = {dv_wy_q[k][DW-2:0], 1'b0};
      end
      dv_remx_d[k+1] = tx[DTW-1:0];
      dv_remy_d[k+1] = ty[DTW-1:0];
    end
  end

  // ---------------------------------------------------------------- output
  function automatic logic [XW:0] fix_out(input logic [DW-1:0] q, input logic neg);
    logic [QXW-1:0] qx;
    logic [QXW-1:0] nq;
    logic [XW:0]    r;
    qx = QXW'(q);
    nq = QXW'(0) - qx;
    if (neg) begin
      if (qx > NEG_LIM) r = {1'b1, NEG_LIM[XW-1:0]};
      else              r = {1'b0, nq[XW-1:0]};
    end else begin
      if (qx > POS_LIM) r = {1'b1, POS_LIM[XW-1:0]};
      else              r = {1'b0, qx[XW-1:0]};
    end
    return r;
  endfunction

  logic [XW:0]                 fx, fy;
  logic [lsi_pkg::RES_TW-1:0]  pipe_data;
  logic [lsi_pkg::RES_TW-1:0]  out_data_q, skid_data_q;
  logic                        out_v_q, skid_v_q;

  always_comb begin
    fx = fix_out(dv_wx_q[DW], dv_negx_q[DW]);
    fy = fix_out(dv_wy_q[DW], dv_negy_q[DW]);
    if (dv_par_q[DW]) begin
      pipe_data = {{PADW{1'b0}}, 1'b0, 1'b0, {XW{1'b0}}, {XW{1'b0}}, 1'b1};
    end else begin
      pipe_data = {{PADW{1'b0}}, fx[XW] | fy[XW], dv_on_q[DW],
                   fy[XW-1:0], fx[XW-1:0], 1'b0};
    end
  end

  assign en              = ~skid_v_q;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      for (int k = 0; k <= DW; k++) begin
        dv_v_q[k] <= 1'b0;
      end
    end else if (en) begin
      s1_v_q    <= s_axis_tvalid_i;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      s4_v_q    <= s3_v_q;
      s5_v_q    <= s4_v_q;
      s6_v_q    <= s5_v_q;
      dv_v_q[0] <= s6_v_q;
      for (int k = 0; k < DW; k++) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      for (int i = 0; i < 8; i++) begin
        s1_pt_q[i] <= pt_in[i];
      end
      s1_a1_q <= $signed({pt_in[3][N-1], pt_in[3]}) - $signed({pt_in[1][N-1], pt_in[1]});
      s1_b1_q <= $signed({pt_in[0][N-1], pt_in[0]}) - $signed({pt_in[2][N-1], pt_in[2]});
      s1_a2_q <= $signed({pt_in[7][N-1], pt_in[7]}) - $signed({pt_in[5][N-1], pt_in[5]});
      s1_b2_q <= $signed({pt_in[4][N-1], pt_in[4]}) - $signed({pt_in[6][N-1], pt_in[6]});
      // stage 2
      s2_pt_q  <= s1_pt_q;
      s2_a1_q  <= s1_a1_q;
      s2_b1_q  <= s1_b1_q;
      s2_a2_q  <= s1_a2_q;
      s2_b2_q  <= s1_b2_q;
      s2_ax1_q <= s1_a1_q * s1_pt_q[0];
      s2_by1_q <= s1_b1_q * s1_pt_q[1];
      s2_ax2_q <= s1_a2_q * s1_pt_q[4];
      s2_by2_q <= s1_b2_q * s1_pt_q[5];
      s2_d1_q  <= s1_a1_q * s1_b2_q;
      s2_d2_q  <= s1_b1_q * s1_a2_q;
      // stage 3
      s3_pt_q  <= s2_pt_q;
      s3_a1_q  <= s2_a1_q;
      s3_b1_q  <= s2_b1_q;
      s3_a2_q  <= s2_a2_q;
      s3_b2_q  <= s2_b2_q;
      s3_c1_q  <= CW'(s2_ax1_q) + CW'(s2_by1_q);
      s3_c2_q  <= CW'(s2_ax2_q) + CW'(s2_by2_q);
      s3_det_q <= DTW'(s2_d1_q) - DTW'(s2_d2_q);
      // stage 4
      s4_pt_q  <= s3_pt_q;
      s4_det_q <= s3_det_q;
      s4_nx1_q <= s3_c1_q * s3_b2_q;
      s4_nx2_q <= s3_b1_q * s3_c2_q;
      s4_ny1_q <= s3_a1_q * s3_c2_q;
      s4_ny2_q <= s3_a2_q * s3_c1_q;
      // stage 5
      s5_nx_q  <= s5_nx_d;
      s5_ny_q  <= s5_ny_d;
      s5_den_q <= s5_den_d;
      s5_par_q <= (s4_det_q == '0);
      s5_lo_q  <= s5_lo_d;
      s5_hi_q  <= s5_hi_d;
      // stage 6
      s6_nx_q   <= s5_nx_q;
      s6_ny_q   <= s5_ny_q;
      s6_negx_q <= s5_nx_q[MW-1];
      s6_negy_q <= s5_ny_q[MW-1];
      s6_magx_q <= s5_nx_q[MW-1] ? MW'(-s5_nx_q) : MW'(s5_nx_q);
      s6_magy_q <= s5_ny_q[MW-1] ? MW'(-s5_ny_q) : MW'(s5_ny_q);
      s6_den_q  <= s5_den_q;
      s6_par_q  <= s5_par_q;
      for (int j = 0; j < 4; j++) begin
        s6_lop_q[j] <= s5_lo_q[j] * den_s;
        s6_hip_q[j] <= s5_hi_q[j] * den_s;
      end
      // divider load
      dv_den_q[0]  <= s6_den_q;
      dv_negx_q[0] <= s6_negx_q;
      dv_negy_q[0] <= s6_negy_q;
      dv_par_q[0]  <= s6_par_q;
      dv_on_q[0]   <= on_d;
      // divider stages
      for (int k = 0; k <= DW; k++) begin
        dv_remx_q[k] <= dv_remx_d[k];
        dv_remy_q[k] <= dv_remy_d[k];
        dv_wx_q[k]   <= dv_wx_d[k];
        dv_wy_q[k]   <= dv_wy_d[k];
      end
      for (int k = 0; k < DW; k++) begin
        dv_den_q[k+1]  <= dv_den_q[k];
        dv_negx_q[k+1] <= dv_negx_q[k];
        dv_negy_q[k+1] <= dv_negy_q[k];
        dv_par_q[k+1]  <= dv_par_q[k];
        dv_on_q[k+1]   <= dv_on_q[k];
      end
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (dv_v_q[DW]) begin
        if (!out_v_q || m_axis_tready_i) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end else if (m_axis_tready_i) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_v_q[DW]) begin
        if (!out_v_q || m_axis_tready_i) begin
          out_data_q <= pipe_data;
        end else begin
          skid_data_q <= pipe_data;
        end
      end
    end else if (m_axis_tready_i) begin
      out_data_q <= skid_data_q;
    end
  end

endmodule
